// ===== rtl/core/positional_list_table_core_assert.svh =====
// assertion macros shared by the list table rtl
`ifndef POSITIONAL_LIST_TABLE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_TABLE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PLT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define PLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/plt_pkg.sv =====
package plt_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int IDX_W = $clog2(LIST_DEPTH);
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int POS_W = 7;
	// common width for position / count compares
	localparam int WIDE_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		OP_SEARCH  = 2'd0,
		OP_REPLACE = 2'd1,
		OP_DELETE  = 2'd2,
		OP_INSERT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_WALK  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_PUT   = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

endpackage

// ===== rtl/core/positional_list_table_core.sv =====
// replace, rejected requests, searches of an empty list, deletes of the last entry and
//   inserts at the end answer in the cycle after the word is taken; a search, a delete at
//   p < n and an insert at p <= n walk the entry ram, drain, and put for insert, then answer
// throughput: one request at a time, the entry ram walks one entry a cycle; the next word is
//   taken the cycle after the result word leaves
// reset: arst_n clears the entry count and the sequencer; entry ram contents are not cleared
`include "positional_list_table_core_assert.svh"

module positional_list_table_core
	import plt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] found_position, [13:7] entry_count, [15:14] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	state_t                  state_q;
	op_t                     op_q;
	logic [VAL_W-1:0]        value_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        ptr_q;
	logic [IDX_W-1:0]        end_q;
	logic [CNT_W-1:0]        hit_q;
	logic [CNT_W-1:0]        hit_nxt;
	status_t                 status_q;
	logic [POS_W-1:0]        fpos_q;

	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic [VAL_W-1:0]        rd_data_s1;

	logic [VAL_W-1:0]        mem [LIST_DEPTH];

	logic                    acc;
	op_t                     in_op;
	logic [VAL_W-1:0]        in_value;
	logic [POS_W-1:0]        in_pos;
	logic [WIDE_W-1:0]       pos_w;
	logic [WIDE_W-1:0]       cnt_w;
	logic                    in_list;
	logic                    in_ins;
	logic                    full;
	logic                    ins_end;

	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic [VAL_W-1:0]        wr_data;

	// input word unpacking and position checks
	assign in_op    = op_t'(s_tuser);
	assign in_value = s_tdata[VAL_W-1:0];
	assign in_pos   = s_tdata[VAL_W+POS_W-1:VAL_W];
	assign acc      = s_tvalid && s_tready;
	assign pos_w    = WIDE_W'(in_pos);
	assign cnt_w    = WIDE_W'(cnt_q);
	assign in_list  = (pos_w != '0) && (pos_w <= cnt_w);
	assign in_ins   = (pos_w != '0) && (pos_w <= cnt_w + WIDE_W'(1));
	assign full     = (cnt_q == CNT_W'(LIST_DEPTH));
	assign ins_end  = (pos_w == cnt_w + WIDE_W'(1));

	// handshake and result word
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_RESP);
	assign m_tuser  = status_q;
	assign m_tdata  = {2'b00, POS_W'(cnt_q), fpos_q};

	// compare unit: last matching index wins
	always_comb begin
		hit_nxt = hit_q;
		if (rd_vld_s1 && (op_q == OP_SEARCH) && (rd_data_s1 == value_q)) begin
			hit_nxt = CNT_W'(rd_idx_s1) + CNT_W'(1);
		end
	end

	// ram write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data_s1;
		if (rd_vld_s1 && (op_q == OP_DELETE)) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1 - IDX_W'(1);
		end else if (rd_vld_s1 && (op_q == OP_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1 + IDX_W'(1);
		end else if (state_q == S_PUT) begin
			wr_en   = 1'b1;
			wr_addr = end_q;
			wr_data = value_q;
		end else if (acc && (in_op == OP_REPLACE) && in_list) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(in_pos - POS_W'(1));
			wr_data = in_value;
		end else if (acc && (in_op == OP_INSERT) && in_ins && !full && ins_end) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(cnt_q);
			wr_data = in_value;
		end
	end

	// entry ram, registered read at the walk pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[ptr_q];
	end

	// read tag stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= (state_q == S_WALK);
			rd_idx_s1 <= ptr_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_SEARCH;
			value_q  <= '0;
			cnt_q    <= '0;
			ptr_q    <= '0;
			end_q    <= '0;
			hit_q    <= '0;
			status_q <= ST_OK;
			fpos_q   <= '0;
		end else begin
			hit_q <= hit_nxt;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						op_q     <= in_op;
						value_q  <= in_value;
						hit_q    <= '0;
						fpos_q   <= '0;
						status_q <= ST_OK;
						state_q  <= S_RESP;
						case (in_op)
							OP_SEARCH: begin
								if (cnt_q == '0) begin
									status_q <= ST_NOTFOUND;
								end else begin
									ptr_q   <= '0;
									end_q   <= IDX_W'(cnt_q - CNT_W'(1));
									state_q <= S_WALK;
								end
							end
							OP_REPLACE: begin
								if (!in_list) begin
									status_q <= ST_BADPOS;
								end
							end
							OP_DELETE: begin
								if (!in_list) begin
									status_q <= ST_BADPOS;
								end else begin
									cnt_q <= cnt_q - CNT_W'(1);
									if (pos_w != cnt_w) begin
										ptr_q   <= IDX_W'(in_pos);
										end_q   <= IDX_W'(cnt_q - CNT_W'(1));
										state_q <= S_WALK;
									end
								end
							end
							OP_INSERT: begin
								if (!in_ins) begin
									status_q <= ST_BADPOS;
								end else if (full) begin
									status_q <= ST_FULL;
								end else begin
									cnt_q <= cnt_q + CNT_W'(1);
									if (!ins_end) begin
										ptr_q   <= IDX_W'(cnt_q - CNT_W'(1));
										end_q   <= IDX_W'(in_pos - POS_W'(1));
										state_q <= S_WALK;
									end
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				// one entry read per cycle, up for search and delete, down for insert
				S_WALK: begin
					if (ptr_q == end_q) begin
						state_q <= S_DRAIN;
					end else if (op_q == OP_INSERT) begin
						ptr_q <= ptr_q - IDX_W'(1);
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				// last read word is compared or moved here
				S_DRAIN: begin
					if (op_q == OP_SEARCH) begin
						fpos_q   <= POS_W'(hit_nxt);
						status_q <= (hit_nxt == '0) ? ST_NOTFOUND : ST_OK;
					end
					state_q <= (op_q == OP_INSERT) ? S_PUT : S_RESP;
				end
				// store the inserted value in the opened gap
				S_PUT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`PLT_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(LIST_DEPTH), "entry count above depth")
	`PLT_ASSERT_IMPL(a_one_side, s_tready, !m_tvalid, "input taken while result pending")
	`PLT_ASSERT_NEXT(a_empty_search,
		acc && (in_op == OP_SEARCH) && (cnt_q == '0),
		m_tvalid && (m_tuser == ST_NOTFOUND) && (m_tdata[POS_W-1:0] == '0),
		"empty search must miss at once")
	`PLT_ASSERT_IMPL(a_fpos_zero, m_tvalid && (op_q != OP_SEARCH), fpos_q == '0,
		"found position set on non-search")

endmodule

// ===== tb/tb_positional_list_table_core.sv =====
`timescale 1ns / 100ps

import plt_pkg::*;

typedef struct {
	status_t    status;
	logic [6:0] found_position;
	logic [6:0] entry_count;
} list_answer_t;

// shadow copy of the list table plus the answers still owed by the block
class list_table_shadow;
	logic [31:0]  entries [LIST_DEPTH];
	int unsigned  count;
	list_answer_t pending [$];
	int unsigned  failures;

	function new();
		count = 0;
		failures = 0;
	endfunction

	// apply one accepted request to the shadow list and queue its answer
	function void take_request(op_t op, logic [31:0] value, logic [6:0] position);
		list_answer_t ans;
		int unsigned  pos;
		pos = position;
		ans.status = ST_OK;
		ans.found_position = '0;
		case (op)
			OP_SEARCH: begin
				// last match wins
				ans.status = ST_NOTFOUND;
				for (int i = 0; i < count; i++) begin
					if (entries[i] == value) begin
						ans.status = ST_OK;
						ans.found_position = 7'(i + 1);
					end
				end
			end
			OP_REPLACE: begin
				if (pos < 1 || pos > count) begin
					ans.status = ST_BADPOS;
				end else begin
					entries[pos - 1] = value;
				end
			end
			OP_DELETE: begin
				if (pos < 1 || pos > count) begin
					ans.status = ST_BADPOS;
				end else begin
					// close the gap
					for (int i = pos - 1; i + 1 < count; i++)
						entries[i] = entries[i + 1];
					count--;
				end
			end
			default: begin
				// position is checked before fullness
				if (pos < 1 || pos > count + 1) begin
					ans.status = ST_BADPOS;
				end else if (count >= LIST_DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					for (int i = count; i > pos - 1; i--)
						entries[i] = entries[i - 1];
					entries[pos - 1] = value;
					count++;
				end
			end
		endcase
		ans.entry_count = 7'(count);
		pending.push_back(ans);
	endfunction

	// compare one result word with the oldest queued answer
	function void check_answer(status_t status, logic [6:0] found_position,
			logic [6:0] entry_count);
		list_answer_t want;
		if (pending.size() == 0) begin
			$error("result word with nothing pending: status %0d found_position %0d entry_count %0d",
				status, found_position, entry_count);
			failures++;
			return;
		end
		want = pending.pop_front();
		if (status !== want.status) begin
			$error("status mismatch: expected %0d, got %0d", want.status, status);
			failures++;
		end
		if (found_position !== want.found_position) begin
			$error("found_position mismatch: expected %0d, got %0d",
				want.found_position, found_position);
			failures++;
		end
		if (entry_count !== want.entry_count) begin
			$error("entry_count mismatch: expected %0d, got %0d", want.entry_count, entry_count);
			failures++;
		end
	endfunction
endclass

module tb_positional_list_table_core;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // [31:0] value, [38:32] position, [39] zero
	logic [1:0]  s_tuser = '0;   // [1:0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [6:0] found_position, [13:7] entry_count, [15:14] zero
	logic [1:0]  m_tuser;        // [1:0] status

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	bit          hold_start = 1'b0;
	int unsigned hold_left = 0;
	mix_t        mix = MIX_GROW;
	int unsigned full_inserts = 0;

	list_table_shadow shadow = new();

	positional_list_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watch both word streams at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				shadow.take_request(op_t'(s_tuser), s_tdata[31:0], s_tdata[38:32]);
			if (m_tvalid && m_tready)
				shadow.check_answer(status_t'(m_tuser), m_tdata[6:0], m_tdata[13:7]);
		end
	end

	// result side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_start) begin
			hold_left = 3000;
			hold_start = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// offer one request word, called and left at a falling edge
	task automatic send_request(op_t op, logic [31:0] value, logic [6:0] position);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, position, value};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random request steered to fill, drain or churn the list
	task automatic pick_request(output op_t op, output logic [31:0] value,
			output logic [6:0] position);
		int unsigned r;
		int unsigned n;
		int unsigned hi;
		n = shadow.count;
		if (mix == MIX_GROW && n == LIST_DEPTH) begin
			full_inserts++;
			if (full_inserts > 4) begin
				mix = MIX_SHRINK;
				full_inserts = 0;
			end
		end else if (mix == MIX_SHRINK && n == 0 && $urandom_range(3) == 0) begin
			mix = MIX_GROW;
		end else if ($urandom_range(199) == 0) begin
			mix = mix_t'($urandom_range(2));
		end

		r = $urandom_range(99);
		case (mix)
			MIX_GROW:
				op = (r < 65) ? OP_INSERT : (r < 75) ? OP_DELETE : (r < 88) ? OP_SEARCH : OP_REPLACE;
			MIX_SHRINK:
				op = (r < 65) ? OP_DELETE : (r < 75) ? OP_INSERT : (r < 88) ? OP_SEARCH : OP_REPLACE;
			default:
				op = (r < 30) ? OP_INSERT : (r < 55) ? OP_DELETE : (r < 80) ? OP_SEARCH : OP_REPLACE;
		endcase

		// mostly legal positions, some just outside, some anywhere
		hi = (op == OP_INSERT) ? n + 1 : n;
		r = $urandom_range(99);
		if (r < 80 && hi >= 1) begin
			position = 7'($urandom_range(hi, 1));
		end else if (r < 90) begin
			case ($urandom_range(2))
				0: position = 7'd0;
				1: position = 7'(hi + 1);
				default: position = 7'(hi + 2);
			endcase
		end else begin
			position = 7'($urandom_range(127));
		end

		// values from the list, a small pool for duplicates, or anything
		r = $urandom_range(99);
		if (n > 0 && (r < 40 || (op == OP_SEARCH && r < 70)))
			value = shadow.entries[$urandom_range(n - 1)];
		else if (r < 75)
			value = 32'($urandom_range(8)) - 32'd4;
		else
			value = $urandom;
	endtask

	// stimulus
	initial begin
		op_t         op;
		logic [31:0] value;
		logic [6:0]  position;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list corners
		send_request(OP_SEARCH, 32'd0, 7'd0);
		send_request(OP_DELETE, 32'd0, 7'd1);
		send_request(OP_DELETE, 32'd0, 7'd0);
		send_request(OP_REPLACE, 32'd1, 7'd1);
		send_request(OP_INSERT, 32'd1, 7'd0);
		send_request(OP_INSERT, 32'd1, 7'd2);
		// build a short list with extremes and a duplicate
		send_request(OP_INSERT, 32'h8000_0000, 7'd1);
		send_request(OP_INSERT, 32'h7fff_ffff, 7'd2);
		send_request(OP_INSERT, 32'd5, 7'd1);
		send_request(OP_INSERT, 32'd5, 7'd2);
		// hits report the last match, then a miss
		send_request(OP_SEARCH, 32'd5, 7'd127);
		send_request(OP_SEARCH, 32'h7fff_ffff, 7'd0);
		send_request(OP_SEARCH, 32'hffff_ffff, 7'd0);
		// replace inside and just outside
		send_request(OP_REPLACE, 32'hffff_ffff, 7'd4);
		send_request(OP_REPLACE, 32'd9, 7'd5);
		send_request(OP_REPLACE, 32'd9, 7'd0);
		// delete past the end and far out, then an insert far out
		send_request(OP_DELETE, 32'd0, 7'd5);
		send_request(OP_DELETE, 32'd0, 7'd127);
		send_request(OP_INSERT, 32'd3, 7'd127);
		// delete middle, last, first, then append
		send_request(OP_DELETE, 32'd0, 7'd2);
		send_request(OP_DELETE, 32'd0, 7'd3);
		send_request(OP_DELETE, 32'd0, 7'd1);
		send_request(OP_INSERT, 32'd0, 7'd2);
		send_request(OP_SEARCH, 32'hffff_ffff, 7'd0);

		// random phases with different idle and stall rates
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 53;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 53;
				end
				default: begin
					sender_idle_pct = 31;
					receiver_stall_pct = 31;
				end
			endcase
			for (int k = 0; k < 450; k++) begin
				if (ph == 0 && k == 150)
					hold_start = 1'b1;
				pick_request(op, value, position);
				send_request(op, value, position);
			end
		end
		s_tvalid <= 1'b0;

		// drain, then allow for the longest walk
		while (shadow.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (shadow.failures == 0)
			$display("positional_list_table_core regression: pass");
		else
			$display("positional_list_table_core regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("positional_list_table_core regression: fail");
		$finish;
	end

endmodule
